[rtl/mvc_pkg.sv]
// ----------------------------------------------------------------------------
// mvc_pkg
// Shared codes and curve math for the MIDI volume curve converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mvc_pkg;

    // Curve codes
    localparam logic [2:0] CURVE_GM    = 3'd0;
    localparam logic [2:0] CURVE_LIN   = 3'd1;
    localparam logic [2:0] CURVE_FM    = 3'd2;
    localparam logic [2:0] CURVE_PSG2  = 3'd3;
    localparam logic [2:0] CURVE_PSG3  = 3'd4;
    localparam logic [2:0] CURVE_WINFM = 3'd5;
    localparam int         NUM_CURVES  = 6;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  REG_SOURCE_CURVE = 3'd0;
    localparam logic [2:0]  REG_DEST_CURVE   = 3'd1;
    localparam logic [2:0]  REG_GAIN_DB      = 3'd2;
    localparam logic [2:0]  REG_CHAN_ENABLE  = 3'd3;
    localparam logic [2:0]  REG_CLASS_ENABLE = 3'd4;

    // Status kinds and controller numbers
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [6:0] CC_VOLUME     = 7'h07;
    localparam logic [6:0] CC_EXPRESSION = 7'h0B;

    // Event class enable bits
    localparam int CLASS_VELOCITY   = 0;
    localparam int CLASS_VOLUME     = 1;
    localparam int CLASS_EXPRESSION = 2;

    localparam logic [6:0] VAL_MAX = 7'h7F;

    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned K_GM_Q24 = 64'd202017810;
    localparam longint unsigned K_LIN_Q24 = 64'd6 << 24;

    // WinFM scale divisor (1000 in Q30) and its rounding half
    localparam longint unsigned WINFM_DEN  = 64'd1000 << 30;
    localparam longint unsigned WINFM_HALF = 64'd1000 << 29;

    // Per-word control flags between front and back
    typedef struct packed {
        logic conv;
        logic no_zero;
    } t_ctl;

    // log2 in Q24 by repeated squaring
    function automatic longint unsigned log2_q24(input longint unsigned y);
        longint unsigned m;
        longint unsigned r;
        int n;
        n = 0;
        while ((y >> (n + 1)) != 0) n++;
        m = y << (30 - n);
        r = longint'(n) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        v = v_in;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // sin(pi*x2/508) in Q30
    function automatic longint unsigned sin_q30(input longint unsigned x2);
        longint unsigned th;
        longint unsigned t;
        longint unsigned p;
        longint unsigned s;
        th = PI_Q30 * x2 / 508;
        t = (th * th) >> 30;
        p = Q30_ONE - t / 110;
        p = Q30_ONE - ((t * p) >> 30) / 72;
        p = Q30_ONE - ((t * p) >> 30) / 42;
        p = Q30_ONE - ((t * p) >> 30) / 20;
        p = Q30_ONE - ((t * p) >> 30) / 6;
        s = (th * p) >> 30;
        return (s > Q30_ONE) ? Q30_ONE : s;
    endfunction

    // Curve magnitude in dB at x2/2 with f fractional bits
    function automatic longint unsigned curve_mag(input int curve, input longint unsigned x2,
                                                  input bit stepped, input int f);
        longint unsigned span;
        longint unsigned d;
        longint unsigned r;
        span = 254 - x2;
        case (curve)
            CURVE_GM: begin
                d = (log2_q24(254) - log2_q24(x2)) * K_GM_Q24;
                return (d + (64'd1 << (47 - f))) >> (48 - f);
            end
            CURVE_LIN: begin
                d = (log2_q24(254) - log2_q24(x2)) * K_LIN_Q24;
                return (d + (64'd1 << (47 - f))) >> (48 - f);
            end
            CURVE_FM: return (((span * 3) << f) + 4) / 8;
            CURVE_PSG2: begin
                if (stepped) return ((15 - (x2 >> 4)) * 2) << f;
                return (((span * 30) << f) + 127) / 254;
            end
            CURVE_PSG3: begin
                if (stepped) return ((15 - (x2 >> 4)) * 3) << f;
                return (((span * 45) << f) + 127) / 254;
            end
            default: begin
                r = isqrt64(sin_q30(x2) << 30);
                return ((((Q30_ONE - r) * 42525) << f) + WINFM_HALF) / WINFM_DEN;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/mvc_front.sv]
// ----------------------------------------------------------------------------
// mvc_front
// Accepts events, classifies them, looks up the source curve and adds gain.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_front #(
    parameter int DB_FRAC_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_status,
    input  wire logic [6:0]                i_data_a,
    input  wire logic [6:0]                i_data_b,
    input  wire logic [2:0]                i_source_curve,
    input  wire logic [15:0]               i_gain_db,
    input  wire logic [15:0]               i_chan_enable,
    input  wire logic [2:0]                i_class_enable,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [DB_FRAC_BITS+31:0]       o_word
);

    localparam int MW = DB_FRAC_BITS + 7;   // curve magnitude width
    localparam int SW = DB_FRAC_BITS + 8;   // saturated sum width
    localparam int GW = SW + 2;             // working width

    logic [MW-1:0] w_src_tab [mvc_pkg::NUM_CURVES][128];

    // Source curve tables
    for (genvar gc = 0; gc < mvc_pkg::NUM_CURVES; gc++) begin : g_crv
        for (genvar gi = 0; gi < 128; gi++) begin : g_ent
            if (gi == 0) begin : g_zero
                assign w_src_tab[gc][gi] = '0;
            end else begin : g_val
                localparam longint unsigned V =
                    mvc_pkg::curve_mag(gc, 64'(2 * gi), 1'b1, DB_FRAC_BITS);
                assign w_src_tab[gc][gi] = MW'(V);
            end
        end
    end

    // Scale gain to the dB fraction
    logic signed [GW-1:0] w_gain;
    if (DB_FRAC_BITS >= 8) begin : g_gain_up
        assign w_gain = GW'(signed'(i_gain_db)) <<< (DB_FRAC_BITS - 8);
    end else begin : g_gain_dn
        logic signed [16:0] w_gr;
        assign w_gr   = 17'(signed'(i_gain_db)) + 17'(1 << (7 - DB_FRAC_BITS));
        assign w_gain = GW'(w_gr >>> (8 - DB_FRAC_BITS));
    end

    // Source magnitude lookup
    logic [MW-1:0] w_mag;
    always_comb begin
        case (i_source_curve)
            mvc_pkg::CURVE_GM:    w_mag = w_src_tab[0][i_data_b];
            mvc_pkg::CURVE_LIN:   w_mag = w_src_tab[1][i_data_b];
            mvc_pkg::CURVE_FM:    w_mag = w_src_tab[2][i_data_b];
            mvc_pkg::CURVE_PSG2:  w_mag = w_src_tab[3][i_data_b];
            mvc_pkg::CURVE_PSG3:  w_mag = w_src_tab[4][i_data_b];
            mvc_pkg::CURVE_WINFM: w_mag = w_src_tab[5][i_data_b];
            default:              w_mag = '0;
        endcase
    end

    // Add gain and saturate
    localparam logic signed [GW-1:0] LIM_HI = GW'((1 << (DB_FRAC_BITS + 7)) - 1);
    localparam logic signed [GW-1:0] LIM_LO = -GW'(1 << (DB_FRAC_BITS + 7));
    logic signed [GW-1:0] w_raw;
    logic signed [SW-1:0] w_sum;
    assign w_raw = w_gain - signed'(GW'(w_mag));
    always_comb begin
        if (w_raw > LIM_HI)      w_sum = LIM_HI[SW-1:0];
        else if (w_raw < LIM_LO) w_sum = LIM_LO[SW-1:0];
        else                     w_sum = w_raw[SW-1:0];
    end

    // Classify the event
    mvc_pkg::t_ctl w_ctl;
    logic w_chan_on;
    assign w_chan_on = i_chan_enable[i_status[3:0]];
    always_comb begin
        w_ctl = '0;
        if (w_chan_on && (i_data_b != '0)) begin
            if ((i_status[7:4] == mvc_pkg::KIND_NOTE_OFF) ||
                (i_status[7:4] == mvc_pkg::KIND_NOTE_ON)) begin
                w_ctl.conv    = i_class_enable[mvc_pkg::CLASS_VELOCITY];
                w_ctl.no_zero = 1'b1;
            end else if (i_status[7:4] == mvc_pkg::KIND_CTRL) begin
                if (i_data_a == mvc_pkg::CC_VOLUME)
                    w_ctl.conv = i_class_enable[mvc_pkg::CLASS_VOLUME];
                else if (i_data_a == mvc_pkg::CC_EXPRESSION)
                    w_ctl.conv = i_class_enable[mvc_pkg::CLASS_EXPRESSION];
            end
        end
    end

    // Hold one word until the queue takes it
    logic r_valid;
    logic [DB_FRAC_BITS+31:0] r_word;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= {w_sum, w_ctl, i_data_b, i_data_a, i_status};
        end
    end

endmodule

`default_nettype wire

[rtl/mvc_fifo.sv]
// ----------------------------------------------------------------------------
// mvc_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_fifo #(
    parameter int WIDTH = 38
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_word,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_word
);

    logic [WIDTH-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_word;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) || (r_cnt == 2'd2) |-> (r_wp != r_rp) == (r_cnt == 2'd1))
        else $error("queue pointers disagree with count");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !i_ready |=> r_cnt == 2'd2)
        else $error("queue lost a word while stalled");

endmodule

`default_nettype wire

[rtl/mvc_back.sv]
// ----------------------------------------------------------------------------
// mvc_back
// Maps the dB sum back through the destination curve by a staged search.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_back #(
    parameter int DB_FRAC_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [DB_FRAC_BITS+31:0]  i_word,
    input  wire logic [2:0]                i_dest_curve,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [7:0]                     o_status,
    output logic [6:0]                     o_data_a,
    output logic [6:0]                     o_data_b
);

    localparam int MW = DB_FRAC_BITS + 7;
    localparam int SW = DB_FRAC_BITS + 8;
    localparam int NS = 8;                    // mirror stage plus seven search stages
    localparam logic signed [SW:0] H =
        (SW+1)'(((64'd42525 << DB_FRAC_BITS) + 64'd500) / 64'd1000);

    logic [MW-1:0] w_dst_tab [mvc_pkg::NUM_CURVES][128];

    // Destination thresholds at k - 0.5
    for (genvar gc = 0; gc < mvc_pkg::NUM_CURVES; gc++) begin : g_crv
        for (genvar gi = 0; gi < 128; gi++) begin : g_ent
            if (gi == 0) begin : g_zero
                assign w_dst_tab[gc][gi] = '0;
            end else begin : g_val
                localparam longint unsigned V =
                    mvc_pkg::curve_mag(gc, 64'(2 * gi - 1), 1'b0, DB_FRAC_BITS);
                assign w_dst_tab[gc][gi] = MW'(V);
            end
        end
    end

    // Unpack the queue word
    logic [7:0] w_in_st;
    logic [6:0] w_in_a, w_in_b;
    mvc_pkg::t_ctl w_in_ctl;
    logic signed [SW-1:0] w_in_sum;
    assign {w_in_sum, w_in_ctl, w_in_b, w_in_a, w_in_st} = i_word;

    // Pipeline registers
    logic [NS-1:0]        r_vld;
    logic [7:0]           r_st  [NS];
    logic [6:0]           r_a   [NS];
    logic [6:0]           r_b   [NS];
    logic [6:0]           r_m   [NS];
    mvc_pkg::t_ctl        r_ctl [NS];
    logic                 r_frc [NS];
    logic signed [SW-1:0] r_sum [NS];

    logic w_en;
    assign w_en    = !r_vld[NS-1] || i_ready;
    assign o_ready = w_en;

    // Mirror or force on the destination curve's domain
    logic signed [SW:0] w_s0;
    logic signed [SW-1:0] w_sum0;
    logic w_frc0;
    assign w_s0 = (SW+1)'(w_in_sum);
    always_comb begin
        w_frc0 = 1'b0;
        w_sum0 = w_in_sum;
        if (i_dest_curve > mvc_pkg::CURVE_WINFM) begin
            w_frc0 = 1'b1;
        end else if (i_dest_curve == mvc_pkg::CURVE_WINFM) begin
            if (w_s0 < -(H <<< 1)) begin
                w_frc0 = 1'b1;
                w_sum0 = '0;
            end else if (w_s0 < -H) begin
                w_sum0 = SW'(-(H <<< 1) - w_s0);
            end
        end
    end

    // One search bit per stage
    logic [6:0] w_m_nx [NS];
    assign w_m_nx[0] = '0;
    for (genvar gs = 1; gs < NS; gs++) begin : g_srch
        logic [6:0] w_c;
        logic [MW-1:0] w_t;
        logic signed [SW+1:0] w_d;
        assign w_c = r_m[gs-1] | (7'd1 << (NS - 1 - gs));
        always_comb begin
            case (i_dest_curve)
                mvc_pkg::CURVE_GM:    w_t = w_dst_tab[0][w_c];
                mvc_pkg::CURVE_LIN:   w_t = w_dst_tab[1][w_c];
                mvc_pkg::CURVE_FM:    w_t = w_dst_tab[2][w_c];
                mvc_pkg::CURVE_PSG2:  w_t = w_dst_tab[3][w_c];
                mvc_pkg::CURVE_PSG3:  w_t = w_dst_tab[4][w_c];
                mvc_pkg::CURVE_WINFM: w_t = w_dst_tab[5][w_c];
                default:              w_t = '0;
            endcase
        end
        assign w_d = (SW+2)'(r_sum[gs-1]) + signed'((SW+2)'(w_t));
        assign w_m_nx[gs] = (w_d >= 0) ? w_c : r_m[gs-1];
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0]  <= w_in_st;
            r_a[0]   <= w_in_a;
            r_b[0]   <= w_in_b;
            r_ctl[0] <= w_in_ctl;
            r_frc[0] <= w_frc0;
            r_sum[0] <= w_sum0;
            r_m[0]   <= w_m_nx[0];
            for (int k = 1; k < NS; k++) begin
                r_st[k]  <= r_st[k-1];
                r_a[k]   <= r_a[k-1];
                r_b[k]   <= r_b[k-1];
                r_ctl[k] <= r_ctl[k-1];
                r_frc[k] <= r_frc[k-1];
                r_sum[k] <= r_sum[k-1];
                r_m[k]   <= w_m_nx[k];
            end
        end
    end

    // Final value selection
    logic [6:0] w_conv;
    always_comb begin
        if (r_frc[NS-1])                                   w_conv = mvc_pkg::VAL_MAX;
        else if (r_ctl[NS-1].no_zero && r_m[NS-1] == '0)   w_conv = 7'd1;
        else                                               w_conv = r_m[NS-1];
    end

    assign o_valid  = r_vld[NS-1];
    assign o_status = r_st[NS-1];
    assign o_data_a = r_a[NS-1];
    assign o_data_b = r_ctl[NS-1].conv ? w_conv : r_b[NS-1];

    a_no_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_ctl[NS-1].conv && r_ctl[NS-1].no_zero |-> o_data_b != '0)
        else $error("converted velocity is zero");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld))
        else $error("pipeline moved during stall");
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_ctl[NS-1].conv |-> o_data_b == r_b[NS-1])
        else $error("unconverted value altered");

endmodule

`default_nettype wire

[rtl/midi_volume_curve_converter.sv]
// ----------------------------------------------------------------------------
// midi_volume_curve_converter
// Rewrites MIDI velocity, volume and expression through dB volume curves.
// ----------------------------------------------------------------------------
// One MIDI channel event enters on the slave stream (s_axis_*) and exactly one
// event leaves on the master stream (m_axis_*), in order. Nonzero values of
// note velocity and controllers 7 and 11 of enabled channels and classes are
// mapped from the source curve to dB, offset by the gain and mapped back on
// the destination curve; all other events pass unchanged. Settings are
// written on the cfg channel (index 0 source curve, 1 dest curve, 2 gain, 3
// channel enable, 4 class enable); the user must write them only while no
// event is in flight; the block has no check for this; cfg is always ready.
// Events pass one front stage, the two-word queue and eight back stages (a
// domain check then a seven-stage threshold search over constant curve
// tables). Throughput is one event per cycle. When the receiver stalls, the
// back pipeline holds, the queue fills, and then the front holds and drops
// s_axis_tready. Reset clears all valid flags and loads the default settings.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_volume_curve_converter #(
    parameter int DB_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // status[7:0], data_a[14:8], data_b[21:15]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_status[7:0], out_data_a[14:8], out_data_b[21:15]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [mvc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int QW = DB_FRAC_BITS + 32;

    logic [2:0]  r_source_curve;
    logic [2:0]  r_dest_curve;
    logic [15:0] r_gain_db;
    logic [15:0] r_chan_enable;
    logic [2:0]  r_class_enable;

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_curve <= mvc_pkg::CURVE_GM;
            r_dest_curve   <= mvc_pkg::CURVE_GM;
            r_gain_db      <= '0;
            r_chan_enable  <= 16'hFFFF;
            r_class_enable <= 3'h7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mvc_pkg::REG_SOURCE_CURVE: r_source_curve <= i_cfg_data[2:0];
                mvc_pkg::REG_DEST_CURVE:   r_dest_curve   <= i_cfg_data[2:0];
                mvc_pkg::REG_GAIN_DB:      r_gain_db      <= i_cfg_data;
                mvc_pkg::REG_CHAN_ENABLE:  r_chan_enable  <= i_cfg_data;
                mvc_pkg::REG_CLASS_ENABLE: r_class_enable <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic          w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    logic [QW-1:0] w_f_word, w_q_word;
    logic [7:0]    w_o_st;
    logic [6:0]    w_o_a, w_o_b;

    mvc_front #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_status       (s_axis_tdata[7:0]),
        .i_data_a       (s_axis_tdata[14:8]),
        .i_data_b       (s_axis_tdata[21:15]),
        .i_source_curve (r_source_curve),
        .i_gain_db      (r_gain_db),
        .i_chan_enable  (r_chan_enable),
        .i_class_enable (r_class_enable),
        .o_valid        (w_f_valid),
        .i_ready        (w_f_ready),
        .o_word         (w_f_word)
    );

    mvc_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_word  (w_f_word),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_word  (w_q_word)
    );

    mvc_back #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_word       (w_q_word),
        .i_dest_curve (r_dest_curve),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (w_o_st),
        .o_data_a     (w_o_a),
        .o_data_b     (w_o_b)
    );

    assign m_axis_tdata = {2'b00, w_o_b, w_o_a, w_o_st};

endmodule

`default_nettype wire
